FILE: hw/rtl/fde_pkg.sv
// shared constants and types for the fraction decimal expander
// no dependencies; imported by fraction_decimal_expander
`default_nettype none

package fde_pkg;

  // remainders below this bound get a slot in the first-seen map
  localparam int MaxDenominator = 131072;
  localparam int MapAw          = $clog2(MaxDenominator);

  localparam int NumW  = 17;        // numerator, denominator, remainder
  localparam int IdxW  = 18;        // digit positions
  localparam int TagW  = 16;        // load number / map tag
  localparam int DigW  = 4;         // one decimal digit
  localparam int WorkW = NumW + 4;  // ten times a remainder
  localparam int CntW  = 5;         // step counter of the shared subtractor

  localparam logic [DigW-1:0] DigitSteps = DigW'(4);

  // request operation codes
  localparam logic OpLoad = 1'b0;
  localparam logic OpNext = 1'b1;

  typedef struct packed {
    logic [TagW-1:0] tag;
    logic [IdxW-1:0] pos;
  } map_entry_t;

  localparam int MapW = $bits(map_entry_t);

endpackage

`default_nettype wire

FILE: hw/rtl/fde_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies
`default_nettype none

module fde_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire                      clk_i,
  input  wire                      we_i,
  input  wire  [$clog2(Depth)-1:0] waddr_i,
  input  wire  [Width-1:0]         wdata_i,
  input  wire                      re_i,
  input  wire  [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/fraction_decimal_expander.sv
// fraction to decimal expander: long division with repeating block detection
// depends on fde_pkg and fde_ram (first-seen map of remainders)
//
// usage: requests arrive on the s_axis channel, operation in tuser. a load
// request carries numerator and denominator and answers the integer part; a
// next request answers one fractional digit with its position, whether the
// expansion has terminated and, once a remainder repeats, where the repeating
// block starts. a zero denominator, or a next request with no valid fraction,
// answers divide_error.
// one request is worked at a time through a single shared subtract/compare
// unit: a load takes 17 restoring division steps, a next 4 compare-subtract
// steps and, while no cycle is known and the remainder is nonzero, one map
// read and, unless the remainder repeats, one map write; a zero denominator
// load and a next with no valid fraction skip the division.
// the input is ready again as soon as the result is registered.
// results sit in an output register; while the receiver stalls, the result
// holds and the next request is still taken, but its result waits.
// after reset the map is cleared one entry a cycle, all 131072 entries, while
// no request is taken; the same pass runs inside the load that wraps the 16 bit
// load number, once every 65535 loads.
`default_nettype none

module fraction_decimal_expander
  import fde_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // numerator [16:0], denominator [33:17], zero fill [39:34]
  input  wire  [39:0] s_axis_tdata,
  // operation [0]
  input  wire  [0:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // integer_part [16:0], digit [20:17], digit_index [38:21], terminated [39],
  // cycle_found [40], cycle_start [58:41], divide_error [59], zero fill [63:60]
  output logic [63:0] m_axis_tdata
);

  localparam logic [3:0] StClr  = 4'd0;
  localparam logic [3:0] StIdle = 4'd1;
  localparam logic [3:0] StLdGo = 4'd2;
  localparam logic [3:0] StDiv  = 4'd3;
  localparam logic [3:0] StLRec = 4'd4;
  localparam logic [3:0] StNDig = 4'd5;
  localparam logic [3:0] StNUpd = 4'd6;
  localparam logic [3:0] StNChk = 4'd7;
  localparam logic [3:0] StFin  = 4'd8;

  localparam logic [1:0] ModeNone  = 2'd0;
  localparam logic [1:0] ModeRun   = 2'd1;
  localparam logic [1:0] ModeCycle = 2'd2;

  localparam logic [MapAw-1:0] ClrLast  = MapAw'(MaxDenominator - 1);
  localparam logic [CntW-1:0]  DivLast  = CntW'(NumW - 1);
  localparam logic [CntW-1:0]  DigLast  = CntW'(DigitSteps - 1'b1);

  // architectural state
  logic [3:0]      state_q, state_d;
  logic [1:0]      mode_q, mode_d;
  logic [NumW-1:0] rem_q, rem_d;
  logic [NumW-1:0] div_q, div_d;
  logic [IdxW-1:0] done_q, done_d;
  logic [TagW-1:0] ln_q, ln_d;
  logic [IdxW-1:0] held_q, held_d;
  logic [MapAw-1:0] clr_q, clr_d;
  logic            resume_q, resume_d;

  // working registers
  logic [WorkW-1:0] acc_q, acc_d;
  logic [NumW-1:0]  quo_q, quo_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  // pending result
  logic [NumW-1:0] res_ip_q, res_ip_d;
  logic [DigW-1:0] res_dg_q, res_dg_d;
  logic [IdxW-1:0] res_ix_q, res_ix_d;
  logic            res_te_q, res_te_d;
  logic            res_cf_q, res_cf_d;
  logic [IdxW-1:0] res_cs_q, res_cs_d;
  logic            res_de_q, res_de_d;

  // output register
  logic            out_vld_q, out_vld_d;
  logic [63:0]     out_data_q, out_data_d;

  // request fields
  logic            in_op;
  logic [NumW-1:0] in_num;
  logic [NumW-1:0] in_den;
  logic            in_acc;

  // shared subtract and compare unit
  logic [WorkW-1:0] sub_a, sub_b;
  logic [WorkW:0]   sub_diff;
  logic             sub_ge;

  // map port
  logic             map_we, map_re;
  logic [MapAw-1:0] map_waddr, map_raddr;
  map_entry_t       map_wdata, map_rdata;

  logic [TagW-1:0] ln_inc;
  logic [IdxW-1:0] done_inc;
  logic [NumW-1:0] div_rem;
  logic [NumW-1:0] dig_rem;
  logic            out_free;

  assign in_op  = s_axis_tuser[0];
  assign in_num = s_axis_tdata[NumW-1:0];
  assign in_den = s_axis_tdata[2*NumW-1:NumW];

  assign s_axis_tready = (state_q == StIdle);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_vld_q || m_axis_tready;

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

  assign ln_inc   = ln_q + 1'b1;
  assign done_inc = (done_q == '1) ? done_q : done_q + 1'b1;
  assign div_rem  = acc_q[NumW-1:0];
  assign dig_rem  = acc_q[NumW-1:0];

  always_comb begin
    sub_a = '0;
    sub_b = '0;
    unique case (state_q)
      StDiv: begin
        sub_a = WorkW'({acc_q[NumW-1:0], quo_q[NumW-1]});
        sub_b = WorkW'(div_q);
      end
      StNDig: begin
        // divisor times 8, 4, 2, 1 in turn
        sub_a = acc_q;
        sub_b = WorkW'(div_q) << (2'd3 - cnt_q[1:0]);
      end
      default: begin
      end
    endcase
  end

  assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_ge   = !sub_diff[WorkW];

  always_comb begin
    state_d  = state_q;
    mode_d   = mode_q;
    rem_d    = rem_q;
    div_d    = div_q;
    done_d   = done_q;
    ln_d     = ln_q;
    held_d   = held_q;
    clr_d    = clr_q;
    resume_d = resume_q;
    acc_d    = acc_q;
    quo_d    = quo_q;
    cnt_d    = cnt_q;
    res_ip_d = res_ip_q;
    res_dg_d = res_dg_q;
    res_ix_d = res_ix_q;
    res_te_d = res_te_q;
    res_cf_d = res_cf_q;
    res_cs_d = res_cs_q;
    res_de_d = res_de_q;
    out_vld_d  = out_vld_q && !m_axis_tready;
    out_data_d = out_data_q;
    map_we    = 1'b0;
    map_waddr = clr_q;
    map_wdata = '0;
    map_re    = 1'b0;
    map_raddr = MapAw'(dig_rem);

    unique case (state_q)
      StClr: begin
        map_we = 1'b1;
        clr_d  = clr_q + 1'b1;
        if (clr_q == ClrLast) begin
          state_d  = resume_q ? StLdGo : StIdle;
          resume_d = 1'b0;
        end
      end

      StIdle: begin
        if (in_acc) begin
          res_ip_d = '0;
          res_dg_d = '0;
          res_ix_d = '0;
          res_te_d = 1'b0;
          res_cf_d = 1'b0;
          res_cs_d = '0;
          res_de_d = 1'b0;
          if (in_op == OpLoad) begin
            div_d  = in_den;
            done_d = '0;
            held_d = '0;
            quo_d  = in_num;
            if (ln_inc == '0) begin
              // load number wrapped: wipe the map before going on
              ln_d     = TagW'(1);
              clr_d    = '0;
              resume_d = 1'b1;
              state_d  = StClr;
            end else begin
              ln_d    = ln_inc;
              state_d = StLdGo;
            end
          end else if (mode_q == ModeNone || div_q == '0) begin
            res_de_d = 1'b1;
            state_d  = StFin;
          end else begin
            acc_d   = (WorkW'(rem_q) << 3) + (WorkW'(rem_q) << 1);
            quo_d   = '0;
            cnt_d   = '0;
            state_d = StNDig;
          end
        end
      end

      StLdGo: begin
        if (div_q == '0) begin
          rem_d    = '0;
          mode_d   = ModeNone;
          res_de_d = 1'b1;
          state_d  = StFin;
        end else begin
          acc_d   = '0;
          cnt_d   = '0;
          state_d = StDiv;
        end
      end

      StDiv: begin
        // restoring division, one quotient bit per cycle
        acc_d = sub_ge ? sub_diff[WorkW-1:0]
                       : WorkW'({acc_q[NumW-1:0], quo_q[NumW-1]});
        quo_d = {quo_q[NumW-2:0], sub_ge};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == DivLast) begin
          state_d = StLRec;
        end
      end

      StLRec: begin
        rem_d    = div_rem;
        mode_d   = ModeRun;
        res_ip_d = quo_q;
        res_te_d = (div_rem == '0);
        if (32'(div_rem) < MaxDenominator) begin
          map_we        = 1'b1;
          map_waddr     = MapAw'(div_rem);
          map_wdata.tag = ln_q;
          map_wdata.pos = IdxW'(1);
        end
        state_d = StFin;
      end

      StNDig: begin
        acc_d = sub_ge ? sub_diff[WorkW-1:0] : acc_q;
        quo_d = {quo_q[NumW-2:0], sub_ge};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == DigLast) begin
          state_d = StNUpd;
        end
      end

      StNUpd: begin
        done_d   = done_inc;
        rem_d    = dig_rem;
        res_dg_d = quo_q[DigW-1:0];
        res_ix_d = done_inc;
        res_te_d = (dig_rem == '0);
        state_d  = StFin;
        if (mode_q == ModeCycle) begin
          res_cf_d = 1'b1;
          res_cs_d = held_q;
        end else if (dig_rem != '0 && 32'(dig_rem) < MaxDenominator) begin
          map_re  = 1'b1;
          state_d = StNChk;
        end
      end

      StNChk: begin
        if (map_rdata.tag == ln_q) begin
          held_d   = map_rdata.pos;
          mode_d   = ModeCycle;
          res_cf_d = 1'b1;
          res_cs_d = map_rdata.pos;
        end else begin
          map_we        = 1'b1;
          map_waddr     = MapAw'(rem_q);
          map_wdata.tag = ln_q;
          map_wdata.pos = (done_q == '1) ? done_q : done_q + 1'b1;
        end
        state_d = StFin;
      end

      StFin: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_data_d = {4'b0000, res_de_q, res_cs_q, res_cf_q, res_te_q,
                        res_ix_q, res_dg_q, res_ip_q};
          state_d    = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StClr;
      mode_q    <= ModeNone;
      rem_q     <= '0;
      div_q     <= '0;
      done_q    <= '0;
      ln_q      <= '0;
      held_q    <= '0;
      clr_q     <= '0;
      resume_q  <= 1'b0;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      mode_q    <= mode_d;
      rem_q     <= rem_d;
      div_q     <= div_d;
      done_q    <= done_d;
      ln_q      <= ln_d;
      held_q    <= held_d;
      clr_q     <= clr_d;
      resume_q  <= resume_d;
      cnt_q     <= cnt_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q      <= acc_d;
    quo_q      <= quo_d;
    res_ip_q   <= res_ip_d;
    res_dg_q   <= res_dg_d;
    res_ix_q   <= res_ix_d;
    res_te_q   <= res_te_d;
    res_cf_q   <= res_cf_d;
    res_cs_q   <= res_cs_d;
    res_de_q   <= res_de_d;
    out_data_q <= out_data_d;
  end

  fde_ram #(
    .Width (MapW),
    .Depth (MaxDenominator)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata),
    .re_i    (map_re),
    .raddr_i (map_raddr),
    .rdata_o (map_rdata)
  );

endmodule

`default_nettype wire
